[hw/rtl/itf_pkg.sv]
// Shared types, character codes and helper functions for the timestamp formatter.
// Used by itf_serializer and iso8601_timestamp_formatter; depends on nothing else.

package itf_pkg;

   // Longest formatted line: "YYYY-MM-DDTHH:MM:SSZ".
   localparam int MAX_CHARS = 20;
   localparam int COUNT_W   = $clog2(MAX_CHARS + 1);
   localparam int CHAR_W    = 7;

   // Configuration register indexes and widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_KIND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASIC_FORM  = 2'd1;

   // Output kind codes; the unused code formats date and time.
   localparam logic [1:0] KIND_DATE = 2'd0;
   localparam logic [1:0] KIND_TIME = 2'd1;
   localparam logic [1:0] KIND_BOTH = 2'd2;

   // ASCII codes.
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'h2d;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3a;
   localparam logic [CHAR_W-1:0] CHAR_T     = 7'h54;
   localparam logic [CHAR_W-1:0] CHAR_Z     = 7'h5a;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;

   // Reciprocal for the split of a year below 10000 into hundreds and the rest.
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int          SHIFT_100 = 19;

   // One formatted line, handed from the pipeline to the serializer.
   typedef struct packed {
      logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
      logic [COUNT_W-1:0]               count;
   } line_type;

   // Split a value below 100 into a tens digit (upper nibble) and a ones digit.
   function automatic logic [7:0] split_tens(input logic [6:0] value);
      logic [13:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 14'(value) * 14'd103;
      tens = prod[13:10];
      ones = value - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

   // ASCII code of one decimal digit.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit);
      return CHAR_ZERO + CHAR_W'(digit);
   endfunction

endpackage

[hw/rtl/iso8601_timestamp_formatter.sv]
// Top level of the ISO 8601 timestamp formatter: clamp and digit pipeline,
// line assembly and configuration registers. Depends on itf_pkg and itf_serializer.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   req      | req_valid / req_ready  | year, month, day, hour, minute, second, utc
//   rsp      | rsp_valid / rsp_ready  | one character and its last-character mark
//   csr      | csr_write_enable       | csr_index, csr_write_data
//
// A timestamp passes three register stages (clamp, hundreds split, digit split)
// and is then assembled and loaded into the serializer, which sends its characters.
// A line holds 7 to 20 characters and leaves at one per cycle while rsp_ready is high,
// so the serializer sets the sustained rate; the next line loads as the last one leaves.
// Later timestamps fill the stages meanwhile; a stall on rsp holds every full stage.
// Reset clears the valid bits and sets date and time in extended form.

module iso8601_timestamp_formatter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [15:0]                   req_year_since_1900,
   input  logic signed [7:0]                    req_month_index,
   input  logic signed [7:0]                    req_day_of_month,
   input  logic signed [7:0]                    req_hour_value,
   input  logic signed [7:0]                    req_minute_value,
   input  logic signed [7:0]                    req_second_value,
   input  logic                                 req_utc_flag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [itf_pkg::CHAR_W-1:0]           rsp_character,
   output logic                                 rsp_last_char,
   input  logic                                 csr_write_enable,
   input  logic [itf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [itf_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import itf_pkg::*;

   // Configuration registers.
   logic [1:0] output_kind_ff;
   logic       basic_form_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_kind_ff <= KIND_BOTH;
         basic_form_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OUTPUT_KIND: output_kind_ff <= csr_write_data[1:0];
            CSR_BASIC_FORM:  basic_form_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Stage handshake: each stage moves when the one after it can take the beat.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_ready, s2_ready, s3_ready, load_ready;

   assign s3_ready  = !s3_valid_ff || load_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage 1: clamp every field to its legal span.
   logic signed [16:0] year_sum;
   logic signed [8:0]  month_sum;
   logic [13:0]        year_clamp;
   logic [3:0]         month_clamp;
   logic [4:0]         day_clamp;
   logic [4:0]         hour_clamp;
   logic [5:0]         minute_clamp;
   logic [5:0]         second_clamp;

   always_comb begin
      year_sum  = 17'(req_year_since_1900) + 17'sd1900;
      month_sum = 9'(req_month_index) + 9'sd1;

      if (year_sum < 17'sd0)         year_clamp = 14'd0;
      else if (year_sum > 17'sd9999) year_clamp = 14'd9999;
      else                           year_clamp = year_sum[13:0];

      if (month_sum < 9'sd1)         month_clamp = 4'd1;
      else if (month_sum > 9'sd12)   month_clamp = 4'd12;
      else                           month_clamp = month_sum[3:0];

      if (req_day_of_month < 8'sd1)        day_clamp = 5'd1;
      else if (req_day_of_month > 8'sd31)  day_clamp = 5'd31;
      else                                 day_clamp = req_day_of_month[4:0];

      if (req_hour_value < 8'sd0)          hour_clamp = 5'd0;
      else if (req_hour_value > 8'sd24)    hour_clamp = 5'd24;
      else                                 hour_clamp = req_hour_value[4:0];

      if (req_minute_value < 8'sd0)        minute_clamp = 6'd0;
      else if (req_minute_value > 8'sd60)  minute_clamp = 6'd60;
      else                                 minute_clamp = req_minute_value[5:0];

      if (req_second_value < 8'sd0)        second_clamp = 6'd0;
      else if (req_second_value > 8'sd60)  second_clamp = 6'd60;
      else                                 second_clamp = req_second_value[5:0];
   end

   logic [13:0] s1_year_ff;
   logic [3:0]  s1_month_ff;
   logic [4:0]  s1_day_ff;
   logic [4:0]  s1_hour_ff;
   logic [5:0]  s1_minute_ff;
   logic [5:0]  s1_second_ff;
   logic        s1_utc_ff;

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_year_ff   <= year_clamp;
         s1_month_ff  <= month_clamp;
         s1_day_ff    <= day_clamp;
         s1_hour_ff   <= hour_clamp;
         s1_minute_ff <= minute_clamp;
         s1_second_ff <= second_clamp;
         s1_utc_ff    <= req_utc_flag;
      end
   end

   // Stage 2: hundreds of the year by reciprocal multiplication.
   logic [26:0] year_prod;
   logic [6:0]  year_hi;

   assign year_prod = 27'(s1_year_ff) * 27'(RECIP_100);
   assign year_hi   = year_prod[SHIFT_100+6:SHIFT_100];

   logic [13:0] s2_year_ff;
   logic [6:0]  s2_year_hi_ff;
   logic [3:0]  s2_month_ff;
   logic [4:0]  s2_day_ff;
   logic [4:0]  s2_hour_ff;
   logic [5:0]  s2_minute_ff;
   logic [5:0]  s2_second_ff;
   logic        s2_utc_ff;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_year_ff    <= s1_year_ff;
         s2_year_hi_ff <= year_hi;
         s2_month_ff   <= s1_month_ff;
         s2_day_ff     <= s1_day_ff;
         s2_hour_ff    <= s1_hour_ff;
         s2_minute_ff  <= s1_minute_ff;
         s2_second_ff  <= s1_second_ff;
         s2_utc_ff     <= s1_utc_ff;
      end
   end

   // Stage 3: remainder of the year and the digits of the two-digit fields.
   logic [13:0] year_rest;

   assign year_rest = s2_year_ff - 14'(s2_year_hi_ff) * 14'd100;

   logic [7:0] s3_year_hi_ff;
   logic [6:0] s3_year_lo_ff;
   logic [7:0] s3_month_ff;
   logic [7:0] s3_day_ff;
   logic [7:0] s3_hour_ff;
   logic [7:0] s3_minute_ff;
   logic [7:0] s3_second_ff;
   logic       s3_utc_ff;

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_year_hi_ff <= split_tens(s2_year_hi_ff);
         s3_year_lo_ff <= year_rest[6:0];
         s3_month_ff   <= split_tens(7'(s2_month_ff));
         s3_day_ff     <= split_tens(7'(s2_day_ff));
         s3_hour_ff    <= split_tens(7'(s2_hour_ff));
         s3_minute_ff  <= split_tens(7'(s2_minute_ff));
         s3_second_ff  <= split_tens(7'(s2_second_ff));
         s3_utc_ff     <= s2_utc_ff;
      end
   end

   // Line assembly: date and time parts, then placed by the output kind.
   logic [7:0]              year_lo_digits;
   logic [9:0][CHAR_W-1:0]  date_chars;
   logic [9:0][CHAR_W-1:0]  time_chars;
   logic [COUNT_W-1:0]      date_len;
   logic [COUNT_W-1:0]      time_len;
   line_type                line;

   assign year_lo_digits = split_tens(s3_year_lo_ff);

   always_comb begin
      date_chars[0] = digit_char(s3_year_hi_ff[7:4]);
      date_chars[1] = digit_char(s3_year_hi_ff[3:0]);
      date_chars[2] = digit_char(year_lo_digits[7:4]);
      date_chars[3] = digit_char(year_lo_digits[3:0]);
      time_chars[0] = CHAR_T;
      time_chars[1] = digit_char(s3_hour_ff[7:4]);
      time_chars[2] = digit_char(s3_hour_ff[3:0]);
      if (basic_form_ff) begin
         date_chars[4] = digit_char(s3_month_ff[7:4]);
         date_chars[5] = digit_char(s3_month_ff[3:0]);
         date_chars[6] = digit_char(s3_day_ff[7:4]);
         date_chars[7] = digit_char(s3_day_ff[3:0]);
         date_chars[8] = CHAR_NUL;
         date_chars[9] = CHAR_NUL;
         date_len      = COUNT_W'(8);
         time_chars[3] = digit_char(s3_minute_ff[7:4]);
         time_chars[4] = digit_char(s3_minute_ff[3:0]);
         time_chars[5] = digit_char(s3_second_ff[7:4]);
         time_chars[6] = digit_char(s3_second_ff[3:0]);
         time_chars[7] = CHAR_Z;
         time_chars[8] = CHAR_NUL;
         time_chars[9] = CHAR_NUL;
         time_len      = s3_utc_ff ? COUNT_W'(8) : COUNT_W'(7);
      end else begin
         date_chars[4] = CHAR_DASH;
         date_chars[5] = digit_char(s3_month_ff[7:4]);
         date_chars[6] = digit_char(s3_month_ff[3:0]);
         date_chars[7] = CHAR_DASH;
         date_chars[8] = digit_char(s3_day_ff[7:4]);
         date_chars[9] = digit_char(s3_day_ff[3:0]);
         date_len      = COUNT_W'(10);
         time_chars[3] = CHAR_COLON;
         time_chars[4] = digit_char(s3_minute_ff[7:4]);
         time_chars[5] = digit_char(s3_minute_ff[3:0]);
         time_chars[6] = CHAR_COLON;
         time_chars[7] = digit_char(s3_second_ff[7:4]);
         time_chars[8] = digit_char(s3_second_ff[3:0]);
         time_chars[9] = CHAR_Z;
         time_len      = s3_utc_ff ? COUNT_W'(10) : COUNT_W'(9);
      end

      line.chars = '0;
      case (output_kind_ff)
         KIND_DATE: begin
            for (int i = 0; i < 10; i++) line.chars[i] = date_chars[i];
            line.count = date_len;
         end
         KIND_TIME: begin
            for (int i = 0; i < 10; i++) line.chars[i] = time_chars[i];
            line.count = time_len;
         end
         default: begin
            // The time part starts right after the date part.
            for (int i = 0; i < 10; i++) line.chars[i] = date_chars[i];
            if (basic_form_ff) begin
               for (int i = 0; i < 10; i++) line.chars[i+8] = time_chars[i];
            end else begin
               for (int i = 0; i < 10; i++) line.chars[i+10] = time_chars[i];
            end
            line.count = date_len + time_len;
         end
      endcase
   end

   itf_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .load_valid    (s3_valid_ff),
      .load_ready    (load_ready),
      .load_line     (line),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

   // A full stage that cannot move keeps its beat.
   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !load_ready) |=> s3_valid_ff)
      else $error("stage 3 lost a beat under stall");

   // A beat accepted at the input reaches stage 1.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted beat did not enter stage 1");

   // Stage 2 only moves into an empty or draining stage 3.
   a_s2_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_ready && s3_valid_ff) |-> load_ready)
      else $error("stage 2 overwrote a waiting beat");

endmodule

[hw/rtl/itf_serializer.sv]
// Output stage: holds one formatted line and sends it one character per beat.
// Depends on itf_pkg for line_type and the width constants.

module itf_serializer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_valid,
   output logic                        load_ready,
   input  itf_pkg::line_type           load_line,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [itf_pkg::CHAR_W-1:0]  rsp_character,
   output logic                        rsp_last_char
);
   import itf_pkg::*;

   logic [MAX_CHARS-1:0][CHAR_W-1:0] chars_ff, chars_in;
   logic [COUNT_W-1:0]               count_ff, count_in;
   logic                             fire;

   // The head character is always at position zero.
   assign rsp_valid     = (count_ff != '0);
   assign rsp_character = chars_ff[0];
   assign rsp_last_char = (count_ff == COUNT_W'(1));
   assign fire          = rsp_valid && rsp_ready;

   // A new line may enter while the last character of the current one leaves.
   assign load_ready = !rsp_valid || (fire && rsp_last_char);

   // Shift the line down one place per beat, or load a new one.
   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      if (load_valid && load_ready) begin
         chars_in = load_line.chars;
         count_in = load_line.count;
      end else if (fire) begin
         for (int i = 0; i < MAX_CHARS - 1; i++) begin
            chars_in[i] = chars_ff[i+1];
         end
         chars_in[MAX_CHARS-1] = CHAR_NUL;
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A taken character that is not the last leaves another one waiting.
   a_more_after_middle: assert property (@(posedge clock) disable iff (reset)
      (fire && !rsp_last_char) |=> rsp_valid)
      else $error("serializer ran dry in the middle of a line");

   // Every loaded line holds between seven and twenty characters.
   a_load_length: assert property (@(posedge clock) disable iff (reset)
      (load_valid && load_ready) |=>
         (count_ff >= COUNT_W'(7) && count_ff <= COUNT_W'(MAX_CHARS)))
      else $error("loaded line has an impossible length");

   // A line is never overwritten before its last character is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load_valid && load_ready && rsp_valid) |-> (rsp_ready && rsp_last_char))
      else $error("line loaded over one still being sent");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for iso8601_timestamp_formatter: drives broken-down times,
// predicts the ASCII character stream of each timestamp and checks every character beat.
// Depends on itf_pkg and the formatter RTL only.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import itf_pkg::*;

   // Register indexes that the block has no register behind; writes must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   // The unused output kind code, which formats date and time.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Cycles without any beat before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Cycles allowed after the last character for the three pipeline stages to empty.
   localparam int DRAIN_CYCLES = 8;

   // One broken-down time as presented on the request channel.
   typedef struct packed {
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic        utc;
   } stamp_type;

   // One character beat on the result channel.
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } char_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   stamp_type              req_stamp = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAR_W-1:0]      rsp_character;
   logic                   rsp_last_char;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Timestamps waiting to be driven and characters waiting to arrive.
   stamp_type     pending_stamps[$];
   char_beat_type expected_chars[$];

   // Shadow copy of the configuration registers, as set after reset.
   logic [1:0] out_kind   = KIND_BOTH;
   logic       form_basic = 1'b0;

   // Percentage of cycles in which each side holds back.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int errors = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   iso8601_timestamp_formatter i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_year_since_1900 (req_stamp.year),
      .req_month_index     (req_stamp.month),
      .req_day_of_month    (req_stamp.day),
      .req_hour_value      (req_stamp.hour),
      .req_minute_value    (req_stamp.minute),
      .req_second_value    (req_stamp.second),
      .req_utc_flag        (req_stamp.utc),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_character       (rsp_character),
      .rsp_last_char       (rsp_last_char),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // Saturate a value to a closed span.
   function automatic int clamp(input int value, input int lo, input int hi);
      if (value < lo) begin
         return lo;
      end
      if (value > hi) begin
         return hi;
      end
      return value;
   endfunction

   function automatic void add_char(input logic [CHAR_W-1:0] code);
      expected_chars.push_back('{character: code, last: 1'b0});
   endfunction

   // Append a zero-padded decimal number, most significant digit first.
   function automatic void add_digits(input int value, input int width);
      int scale;
      scale = 1;
      for (int i = 1; i < width; i++) begin
         scale *= 10;
      end
      for (int i = 0; i < width; i++) begin
         add_char(CHAR_ZERO + CHAR_W'((value / scale) % 10));
         scale /= 10;
      end
   endfunction

   // Work out the characters of one timestamp under the current settings.
   function automatic void format_stamp(input stamp_type s);
      logic extended;
      extended = !form_basic;
      if (out_kind != KIND_TIME) begin
         add_digits(clamp(1900 + int'($signed(s.year)), 0, 9999), 4);
         if (extended) begin
            add_char(CHAR_DASH);
         end
         add_digits(clamp(int'($signed(s.month)) + 1, 1, 12), 2);
         if (extended) begin
            add_char(CHAR_DASH);
         end
         add_digits(clamp(int'($signed(s.day)), 1, 31), 2);
      end
      if (out_kind != KIND_DATE) begin
         add_char(CHAR_T);
         add_digits(clamp(int'($signed(s.hour)), 0, 24), 2);
         if (extended) begin
            add_char(CHAR_COLON);
         end
         add_digits(clamp(int'($signed(s.minute)), 0, 60), 2);
         if (extended) begin
            add_char(CHAR_COLON);
         end
         add_digits(clamp(int'($signed(s.second)), 0, 60), 2);
         if (s.utc) begin
            add_char(CHAR_Z);
         end
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
   endfunction

   function automatic stamp_type make_stamp(input int year, input int month, input int day,
                                            input int hour, input int minute,
                                            input int second, input bit utc);
      return '{year: 16'(year), month: 8'(month), day: 8'(day), hour: 8'(hour),
               minute: 8'(minute), second: 8'(second), utc: utc};
   endfunction

   // Mostly dates near the legal spans, just past the clamps on both sides;
   // the rest are raw bit patterns over the whole field width.
   function automatic stamp_type random_stamp();
      if ($urandom_range(99) < 70) begin
         return make_stamp(int'($urandom_range(10100)) - 1950, int'($urandom_range(13)) - 1,
                           int'($urandom_range(32)), int'($urandom_range(26)) - 1,
                           int'($urandom_range(62)) - 1, int'($urandom_range(62)) - 1,
                           1'($urandom_range(1)));
      end
      return '{year: 16'($urandom), month: 8'($urandom), day: 8'($urandom),
               hour: 8'($urandom), minute: 8'($urandom), second: 8'($urandom),
               utc: 1'($urandom_range(1))};
   endfunction

   // Request driver: present the next timestamp whenever the slot is free and the
   // sender is not idling; predict the characters of each accepted beat.
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            format_stamp(req_stamp);
         end
         if (!req_valid || req_ready) begin
            if (pending_stamps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_stamp <= pending_stamps.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare every character beat with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      char_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected character beat: expected none, actual %h last %b",
                        $time, rsp_character, rsp_last_char);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.character) begin
                  errors++;
                  $display("%0t: character mismatch: expected %h (%c), actual %h (%c)",
                           $time, want.character, want.character, rsp_character,
                           rsp_character);
               end
               if (rsp_last_char !== want.last) begin
                  errors++;
                  $display("%0t: last_char mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last_char);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a long stretch with no beat on either channel means the block hung.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Wait until every timestamp went in and every character came out, then let
   // the pipeline settle.
   task automatic wait_drained();
      while (pending_stamps.size() != 0 || req_valid || expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the shadow copy follows the same decode as the block.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      if (index == CSR_OUTPUT_KIND) begin
         out_kind = data;
      end else if (index == CSR_BASIC_FORM) begin
         form_basic = data[0];
      end
   endtask

   // New settings, with junk in the unused data bit and writes to the spare indexes.
   task automatic apply_setting(input logic [1:0] kind, input logic basic);
      write_csr(CSR_SPARE_2, CSR_DATA_W'($urandom));
      write_csr(CSR_OUTPUT_KIND, kind);
      write_csr(CSR_BASIC_FORM, {1'($urandom), basic});
      write_csr(CSR_SPARE_3, CSR_DATA_W'($urandom));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_random(input int count);
      repeat (count) pending_stamps.push_back(random_stamp());
   endtask

   task automatic run_phase(input logic [1:0] kind, input logic basic, input int count);
      wait_drained();
      apply_setting(kind, basic);
      queue_random(count);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sender idles less than the receiver.
      send_idle_pct = 29;
      recv_idle_pct = 59;

      // Directed timestamps under the reset settings (date and time, extended form).
      pending_stamps.push_back(make_stamp(100, 0, 1, 0, 0, 0, 0));
      pending_stamps.push_back(make_stamp(-1900, 0, 1, 0, 0, 0, 1));
      pending_stamps.push_back(make_stamp(-32768, -128, -128, -128, -128, -128, 0));
      pending_stamps.push_back(make_stamp(32767, 127, 127, 127, 127, 127, 1));
      pending_stamps.push_back(make_stamp(8099, 11, 31, 23, 59, 59, 1));
      pending_stamps.push_back(make_stamp(8100, 12, 32, 25, 61, 61, 0));
      pending_stamps.push_back(make_stamp(-1901, -1, 0, -1, -1, -1, 1));
      pending_stamps.push_back(make_stamp(124, 5, 15, 24, 60, 60, 1));
      pending_stamps.push_back(make_stamp(-1, 8, 9, 9, 9, 9, 0));
      pending_stamps.push_back(make_stamp(-1891, 1, 2, 3, 4, 5, 1));
      pending_stamps.push_back(make_stamp(-1810, 9, 10, 10, 10, 10, 0));
      pending_stamps.push_back(make_stamp(-900, 2, 29, 12, 30, 45, 1));
      pending_stamps.push_back(make_stamp(-666, 6, 7, 8, 9, 10, 0));
      pending_stamps.push_back(make_stamp(21845, 85, 85, 85, 85, 85, 1));
      pending_stamps.push_back(make_stamp(-21846, -86, -86, -86, -86, -86, 0));
      pending_stamps.push_back(make_stamp(7, 3, 31, 19, 0, 59, 1));
      queue_random(30);

      run_phase(KIND_DATE, 1'b1, 35);
      run_phase(KIND_TIME, 1'b0, 35);

      // Receiver idles less than the sender.
      wait_drained();
      send_idle_pct = 59;
      recv_idle_pct = 29;
      run_phase(KIND_SPARE, 1'b1, 35);
      run_phase(KIND_BOTH, 1'b1, 35);

      // No idling; halfway through, the sender holds off until every character is out.
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(KIND_TIME, 1'b1, 20);
      wait_drained();
      queue_random(20);
      run_phase(KIND_DATE, 1'b0, 30);

      wait_drained();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
